// ===== rtl/fpss_pkg.sv =====
package fpss_pkg;

    // sizes
    localparam int MAX_COLS   = 4096;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int NCOLS_W    = COL_W + 1;
    localparam int ROW_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int NUM_TAPS   = 5;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int ACC_W      = PROD_W + 4;
    localparam int FRAC_BITS  = 12;
    localparam int ROUND_BIAS = 2 ** (FRAC_BITS - 1);

    // stream and config port widths, tdata padded to whole bytes
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_W + ROW_W + COL_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // tap order
    localparam int TAP_UP     = 0;
    localparam int TAP_LEFT   = 1;
    localparam int TAP_CENTER = 2;
    localparam int TAP_RIGHT  = 3;
    localparam int TAP_DOWN   = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NUM_COLS    = 3'd0,
        CFG_NUM_ROWS    = 3'd1,
        CFG_COEF_UP     = 3'd2,
        CFG_COEF_LEFT   = 3'd3,
        CFG_COEF_CENTER = 3'd4,
        CFG_COEF_RIGHT  = 3'd5,
        CFG_COEF_DOWN   = 3'd6
    } cfg_index_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam logic [NCOLS_W-1:0] NUM_COLS_RST = NCOLS_W'(128);
    localparam logic [ROW_W-1:0]   NUM_ROWS_RST = ROW_W'(128);
    localparam coef_t              COEF_RST     = COEF_W'(819);

    // position and flag of a computed point
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } point_t;

    // one access to the line stores
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_col;
        logic             wr_en;
        logic [COL_W-1:0] wr_col;
        sample_t          wr_upper;
        sample_t          wr_middle;
    } lstore_req_t;

    typedef struct packed {
        sample_t up;
        sample_t center;
        sample_t right;
    } lstore_rsp_t;

endpackage

// ===== rtl/fpss_line_store.sv =====
module fpss_line_store (
    input  logic                 clk,
    input  fpss_pkg::lstore_req_t req,
    output fpss_pkg::lstore_rsp_t rsp
);
    import fpss_pkg::*;

    sample_t          upper_mem  [MAX_COLS];
    sample_t          middle_mem [MAX_COLS];
    lstore_rsp_t      rsp_reg;
    logic [COL_W-1:0] right_col;

    // wraps past the last entry; that read only happens on a border column
    assign right_col = req.rd_col + COL_W'(1);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            upper_mem[req.wr_col]  <= req.wr_upper;
            middle_mem[req.wr_col] <= req.wr_middle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rsp_reg.up     <= upper_mem[req.rd_col];
            rsp_reg.center <= middle_mem[req.rd_col];
            rsp_reg.right  <= middle_mem[right_col];
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/fpss_mac.sv =====
module fpss_mac (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpss_pkg::sample_t ops   [fpss_pkg::NUM_TAPS],
    input  fpss_pkg::coef_t   coefs [fpss_pkg::NUM_TAPS],
    input  fpss_pkg::point_t  in_point,
    output logic             out_valid,
    input  logic             out_ready,
    output fpss_pkg::sample_t out_value,
    output fpss_pkg::point_t  out_point
);
    import fpss_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // products
    logic                     s2_valid_reg;
    prod_t                    s2_prod_reg [NUM_TAPS];
    point_t                   s2_point_reg;
    logic                     s2_ready;

    // partial sums
    logic                     s3_valid_reg;
    logic signed [PAIR_W-1:0] s3_pair0_reg;
    logic signed [PAIR_W-1:0] s3_pair1_reg;
    prod_t                    s3_tail_reg;
    point_t                   s3_point_reg;
    logic                     s3_ready;

    // output register
    logic                     s4_valid_reg;
    sample_t                  s4_value_reg;
    point_t                   s4_point_reg;
    logic                     s4_ready;

    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  quot;
    sample_t                  s4_value_next;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && in_valid)
        begin
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                s2_prod_reg[i] <= PROD_W'(ops[i]) * PROD_W'(coefs[i]);
            end
            s2_point_reg <= in_point;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_pair0_reg <= PAIR_W'(s2_prod_reg[TAP_UP]) + PAIR_W'(s2_prod_reg[TAP_LEFT]);
            s3_pair1_reg <= PAIR_W'(s2_prod_reg[TAP_CENTER])
                          + PAIR_W'(s2_prod_reg[TAP_RIGHT]);
            s3_tail_reg  <= s2_prod_reg[TAP_DOWN];
            s3_point_reg <= s2_point_reg;
        end
    end

    // round half up by bias and floor shift, then clamp
    always_comb
    begin
        acc  = ACC_W'(s3_pair0_reg) + ACC_W'(s3_pair1_reg) + ACC_W'(s3_tail_reg)
             + ACC_W'(ROUND_BIAS);
        quot = acc >>> FRAC_BITS;
        if (quot > SAT_HI)
        begin
            s4_value_next = SAMPLE_W'(SAT_HI);
        end
        else if (quot < SAT_LO)
        begin
            s4_value_next = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            s4_value_next = SAMPLE_W'(quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
        begin
            s4_value_reg <= s4_value_next;
            s4_point_reg <= s3_point_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_value = s4_value_reg;
    assign out_point = s4_point_reg;

endmodule

// ===== rtl/five_point_star_stencil.sv =====
// Five-point star stencil over a raster-order grid stream. One signed 16-bit
// sample is taken per transfer on the slave side, one per clock when the
// master side keeps up. When the sample at (r+1, c) arrives and (r, c) is an
// interior point, its result passes the read, product, partial-sum and
// output stages: the weighted sum of up, left, center, right and down with
// Q3.12 weights, rounded to nearest (ties up) and saturated to 16 bits, with
// row, column and a last-of-frame flag on tlast. Border rows and columns give
// no transfer. Two line stores of 4096 entries hold the two previous rows;
// each accepted sample costs one read and one write on them, which sets the
// rate at one sample per clock. Line entries are not cleared at reset, so
// the first two rows only prime the stores. Sizes and weights are written on
// the config port while the stream is idle; num_cols below 3 acts as 3 and
// above 4096 as 4096, num_rows below 3 acts as 3.
module five_point_star_stencil (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write port
    input  logic                                 cfg_wr_en,
    input  logic [fpss_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fpss_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // sample input
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fpss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [15:0] sample
    // result output
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fpss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [15:0] out_value,
                                                                 // [31:16] out_row,
                                                                 // [43:32] out_col,
                                                                 // [47:44] zero
    output logic                                 m_axis_tlast    // last_of_frame
);
    import fpss_pkg::*;

    // config registers
    logic [NCOLS_W-1:0] num_cols_reg;
    logic [ROW_W-1:0]   num_rows_reg;
    coef_t              coef_reg [NUM_TAPS];

    // raster position of the next sample
    logic [COL_W-1:0]   col_pos_reg;
    logic [ROW_W-1:0]   row_pos_reg;

    // effective sizes and clamped position
    logic [NCOLS_W-1:0] cols_eff;
    logic [ROW_W-1:0]   rows_eff;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [NCOLS_W-1:0] col_ext;
    logic               row_wrap;
    logic               col_wrap;
    logic               has_result;
    point_t             cur_point;

    // read stage: line store data lands here in the cycle after the transfer
    logic               s1_valid_reg;
    logic               s1_res_reg;
    sample_t            s1_sample_reg;
    logic [COL_W-1:0]   s1_col_reg;
    point_t             s1_point_reg;
    sample_t            left_hold_reg;
    logic               s1_leave;
    logic               accept;

    lstore_req_t        ls_req;
    lstore_rsp_t        ls_rsp;

    logic               mac_in_valid;
    logic               mac_in_ready;
    sample_t            mac_ops [NUM_TAPS];
    logic               mac_out_valid;
    sample_t            mac_out_value;
    point_t             mac_out_point;

    // config writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NUM_COLS_RST;
            num_rows_reg <= NUM_ROWS_RST;
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                coef_reg[i] <= COEF_RST;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_NUM_COLS:    num_cols_reg         <= cfg_wdata[NCOLS_W-1:0];
                CFG_NUM_ROWS:    num_rows_reg         <= cfg_wdata[ROW_W-1:0];
                CFG_COEF_UP:     coef_reg[TAP_UP]     <= cfg_wdata;
                CFG_COEF_LEFT:   coef_reg[TAP_LEFT]   <= cfg_wdata;
                CFG_COEF_CENTER: coef_reg[TAP_CENTER] <= cfg_wdata;
                CFG_COEF_RIGHT:  coef_reg[TAP_RIGHT]  <= cfg_wdata;
                CFG_COEF_DOWN:   coef_reg[TAP_DOWN]   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // position decode for the sample now on the slave side
    always_comb
    begin
        if (num_cols_reg < NCOLS_W'(3))
        begin
            cols_eff = NCOLS_W'(3);
        end
        else if (num_cols_reg > NCOLS_W'(MAX_COLS))
        begin
            cols_eff = NCOLS_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = num_cols_reg;
        end
        rows_eff = (num_rows_reg < ROW_W'(3)) ? ROW_W'(3) : num_rows_reg;

        // a size shrunk mid-frame pins the position to the last column or row
        if ({1'b0, col_pos_reg} >= cols_eff)
        begin
            cur_col = COL_W'(cols_eff - NCOLS_W'(1));
        end
        else
        begin
            cur_col = col_pos_reg;
        end
        cur_row = (row_pos_reg >= rows_eff) ? rows_eff - ROW_W'(1) : row_pos_reg;

        col_ext    = {1'b0, cur_col};
        col_wrap   = (col_ext + NCOLS_W'(1)) >= cols_eff;
        row_wrap   = ({1'b0, cur_row} + (ROW_W + 1)'(1)) >= {1'b0, rows_eff};
        has_result = (cur_row >= ROW_W'(2)) && (cur_col != '0)
                  && ((col_ext + NCOLS_W'(2)) <= cols_eff);

        cur_point.row  = cur_row - ROW_W'(1);
        cur_point.col  = cur_col;
        cur_point.last = (cur_row == rows_eff - ROW_W'(1))
                      && (col_ext == cols_eff - NCOLS_W'(2));
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_leave      = s1_valid_reg && (!s1_res_reg || mac_in_ready);
    // a border sample leaves the read stage without waiting on the adder pipe
    assign s_axis_tready = !s1_valid_reg || s1_leave;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            left_hold_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (col_wrap)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= row_wrap ? '0 : cur_row + ROW_W'(1);
                end
                else
                begin
                    col_pos_reg <= cur_col + COL_W'(1);
                    row_pos_reg <= cur_row;
                end
            end
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            // center of this column is the left neighbor of the next one
            if (s1_leave)
            begin
                left_hold_reg <= ls_rsp.center;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg    <= has_result;
            s1_sample_reg <= s_axis_tdata;
            s1_col_reg    <= cur_col;
            s1_point_reg  <= cur_point;
        end
    end

    // read at transfer, write back when the sample leaves the read stage;
    // the write of one sample and the reads of the next never share an
    // entry (next reads c+1, c+2 or, after a wrap, 0 and 1 with at least
    // three columns), so no forwarding is needed
    always_comb
    begin
        ls_req.rd_en     = accept;
        ls_req.rd_col    = cur_col;
        ls_req.wr_en     = s1_leave;
        ls_req.wr_col    = s1_col_reg;
        ls_req.wr_upper  = ls_rsp.center;
        ls_req.wr_middle = s1_sample_reg;
    end

    fpss_line_store u_line_store (
        .clk (clk),
        .req (ls_req),
        .rsp (ls_rsp)
    );

    assign mac_in_valid         = s1_valid_reg && s1_res_reg;
    assign mac_ops[TAP_UP]      = ls_rsp.up;
    assign mac_ops[TAP_LEFT]    = left_hold_reg;
    assign mac_ops[TAP_CENTER]  = ls_rsp.center;
    assign mac_ops[TAP_RIGHT]   = ls_rsp.right;
    assign mac_ops[TAP_DOWN]    = s1_sample_reg;

    // multiply, pair sums, round and saturate into the output register
    fpss_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mac_in_valid),
        .in_ready  (mac_in_ready),
        .ops       (mac_ops),
        .coefs     (coef_reg),
        .in_point  (s1_point_reg),
        .out_valid (mac_out_valid),
        .out_ready (m_axis_tready),
        .out_value (mac_out_value),
        .out_point (mac_out_point)
    );

    assign m_axis_tvalid = mac_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - SAMPLE_W - ROW_W - COL_W)'(0),
                            mac_out_point.col, mac_out_point.row, mac_out_value};
    assign m_axis_tlast  = mac_out_point.last;

endmodule

// ===== rtl/fpss_checker.sv =====
module fpss_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fpss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);
    import fpss_pkg::*;

    // a stalled result holds its value, position and flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // the top border row never gives a result
    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[SAMPLE_W +: ROW_W] != '0)
        else $error("result for row zero");

    // the left border column never gives a result
    a_col_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[SAMPLE_W + ROW_W +: COL_W] != '0)
        else $error("result for column zero");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:SAMPLE_W + ROW_W + COL_W] == '0)
        else $error("nonzero pad bits in result");

    // the pipe is empty right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_axis_tvalid)
        else $error("result right after reset");

endmodule

bind five_point_star_stencil fpss_checker u_fpss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/five_point_star_stencil_tb.sv =====
`timescale 1ns / 1ps

module five_point_star_stencil_tb;
    import fpss_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 10;
    // the result trails the down sample through the pipeline, allow generous slack
    localparam int SETTLE_CYCLES = 16;
    // cycles with no transfer or register write before the run is declared hung
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 120;
    localparam int HOLD_CYCLES   = 400;

    localparam coef_t   COEF_MAX   = 16'sh7FFF;
    localparam coef_t   COEF_MIN   = 16'sh8000;
    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // one computed grid point as it should leave the block
    typedef struct {
        sample_t          value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } grid_point_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [15:0] out_value, [31:16] out_row,
                                                  // [43:32] out_col, [47:44] zero
    logic                   m_axis_tlast;         // last_of_frame

    // stencil predictor state: line stores, raster position, config copy
    sample_t            upper_row_mem  [MAX_COLS];
    sample_t            middle_row_mem [MAX_COLS];
    int unsigned        grid_row;
    int unsigned        grid_col;
    sample_t            left_sample;
    logic [NCOLS_W-1:0] cols_reg;
    logic [ROW_W-1:0]   rows_reg;
    coef_t              weight [NUM_TAPS];

    // points predicted but not yet seen on the master side, oldest first
    grid_point_t pending_points [$];

    int error_count  = 0;
    int samples_sent = 0;
    int quiet_cycles = 0;
    // random gaps on both sides are allowed while this is set
    bit idle_on      = 1'b1;
    // long receiver hold-off, loaded by a test and counted down by the receiver
    int hold_left    = 0;
    int rx_gap       = 0;

    five_point_star_stencil dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // sizes as the block uses them: clamped to 3..MAX_COLS and 3..
    function automatic int unsigned active_cols();
        if (cols_reg < 3)
            return 3;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return cols_reg;
    endfunction

    function automatic int unsigned active_rows();
        return (rows_reg < 3) ? 3 : rows_reg;
    endfunction

    // add half an lsb, floor shift out the fraction, clamp to the sample range
    function automatic sample_t round_saturate(longint acc);
        longint q;
        longint hi;
        hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        q  = (acc + ROUND_BIAS) >>> FRAC_BITS;
        if (q > hi)
            q = hi;
        else if (q < -hi - 1)
            q = -hi - 1;
        return sample_t'(q);
    endfunction

    // one accepted sample: update line stores and position, maybe queue a point
    function automatic void stencil_step(sample_t s);
        int unsigned cols;
        int unsigned rows;
        int unsigned c;
        int unsigned r;
        sample_t     center;
        longint      acc;
        grid_point_t pt;
        cols = active_cols();
        rows = active_rows();
        c    = grid_col;
        r    = grid_row;
        // a position left beyond a shrunk size acts as the last one
        if (c >= cols)
            c = cols - 1;
        if (r >= rows)
            r = rows - 1;
        center = middle_row_mem[c];
        if (r >= 2 && c >= 1 && c + 2 <= cols) begin
            acc = longint'(weight[TAP_UP])     * longint'(upper_row_mem[c])
                + longint'(weight[TAP_LEFT])   * longint'(left_sample)
                + longint'(weight[TAP_CENTER]) * longint'(center)
                + longint'(weight[TAP_RIGHT])  * longint'(middle_row_mem[c + 1])
                + longint'(weight[TAP_DOWN])   * longint'(s);
            pt.value = round_saturate(acc);
            pt.row   = ROW_W'(r - 1);
            pt.col   = COL_W'(c);
            pt.last  = (r == rows - 1) && (c == cols - 2);
            pending_points.push_back(pt);
        end
        left_sample       = center;
        upper_row_mem[c]  = center;
        middle_row_mem[c] = s;
        if (c + 1 >= cols) begin
            grid_col = 0;
            grid_row = (r + 1 >= rows) ? 0 : r + 1;
        end
        else begin
            grid_col = c + 1;
            grid_row = r;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(0, 63)) - 32);
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic coef_t random_coef();
        case ($urandom_range(0, 4))
            0:       return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
            1:       return '0;
            2:       return coef_t'(int'($urandom_range(0, 8191)) - 4096);
            default: return coef_t'($urandom());
        endcase
    endfunction

    // one register write; en drops for a cycle so back-to-back calls stay clean
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_NUM_COLS: cols_reg = val[NCOLS_W-1:0];
            CFG_NUM_ROWS: rows_reg = val;
            default:      weight[int'(idx) - int'(CFG_COEF_UP)] = coef_t'(val);
        endcase
    endtask

    task automatic write_weights(coef_t up, coef_t left, coef_t center,
                                 coef_t right, coef_t down);
        write_reg(CFG_COEF_UP,     up);
        write_reg(CFG_COEF_LEFT,   left);
        write_reg(CFG_COEF_CENTER, center);
        write_reg(CFG_COEF_RIGHT,  right);
        write_reg(CFG_COEF_DOWN,   down);
    endtask

    // offer one sample, optionally after a random gap, and wait for the transfer
    task automatic send_sample(sample_t s);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        stencil_step(s);
        samples_sent++;
    endtask

    // random samples until the raster position wraps back to the frame start
    task automatic finish_frame();
        do
            send_sample(random_sample());
        while (grid_row != 0 || grid_col != 0);
    endtask

    // stop offering, wait for every predicted point, then let the pipeline empty
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset sizes and weights, then shrink num_rows past the current row
    task automatic test_reset_config();
        repeat (3 * 128) send_sample(random_sample());
        drain_stream();
        // row 3 of a 3-row frame acts as the last row
        write_reg(CFG_NUM_ROWS, CFG_DATA_W'(3));
        finish_frame();
        drain_stream();
    endtask

    // full-scale weights and samples drive the sum past both ends
    task automatic test_saturation();
        sample_t grid [12];
        for (int i = 0; i < 12; i++)
            grid[i] = (i < 6) ? SAMPLE_MAX : SAMPLE_MIN;
        // zero columns acts as three
        write_reg(CFG_NUM_COLS, '0);
        write_reg(CFG_NUM_ROWS, CFG_DATA_W'(4));
        write_weights(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN);
        foreach (grid[i])
            send_sample(grid[i]);
        drain_stream();
    endtask

    // half-lsb ties on both signs: 0.5 rounds to 1, -1.5 rounds to -1
    task automatic test_rounding();
        sample_t grid [12];
        for (int i = 0; i < 12; i++)
            grid[i] = random_sample();
        grid[4] = 16'sd1;
        grid[7] = -16'sd3;
        write_reg(CFG_NUM_COLS, CFG_DATA_W'(2));
        write_reg(CFG_NUM_ROWS, CFG_DATA_W'(4));
        write_weights('0, '0, coef_t'(2048), '0, '0);
        foreach (grid[i])
            send_sample(grid[i]);
        drain_stream();
    endtask

    // long output hold-off with the input kept busy, then a pause mid-frame
    task automatic test_backpressure();
        write_reg(CFG_NUM_COLS, CFG_DATA_W'(12));
        write_reg(CFG_NUM_ROWS, CFG_DATA_W'(12));
        write_weights(random_coef(), random_coef(), random_coef(),
                      random_coef(), random_coef());
        idle_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        finish_frame();
        drain_stream();
        idle_on = 1'b1;
        repeat (60) send_sample(random_sample());
        // sender waits for every expected point before going on
        drain_stream();
        finish_frame();
        drain_stream();
    endtask

    // oversized num_cols acts as MAX_COLS over part of the first row, then a
    // shrink pins the position to the new last column
    task automatic test_large_width();
        write_reg(CFG_NUM_COLS, 16'hFFFF);
        write_reg(CFG_NUM_ROWS, CFG_DATA_W'(3));
        write_weights(random_coef(), random_coef(), random_coef(),
                      random_coef(), random_coef());
        repeat (60) send_sample(random_sample());
        drain_stream();
        write_reg(CFG_NUM_COLS, CFG_DATA_W'(12));
        finish_frame();
        drain_stream();
    endtask

    // small random frames, random weights, some with a size change part way
    task automatic test_random_frames();
        int start_count;
        start_count = samples_sent;
        while (samples_sent - start_count < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_NUM_COLS, CFG_DATA_W'($urandom_range(13, 64)));
            else
                write_reg(CFG_NUM_COLS, CFG_DATA_W'($urandom_range(0, 12)));
            write_reg(CFG_NUM_ROWS, CFG_DATA_W'($urandom_range(0, 8)));
            for (int t = 0; t < NUM_TAPS; t++)
                if ($urandom_range(0, 1) != 0)
                    write_reg(cfg_index_t'(int'(CFG_COEF_UP) + t), random_coef());
            if ($urandom_range(0, 3) == 0) begin
                // both line stores hold written rows before any size change
                while (grid_row < 2)
                    send_sample(random_sample());
                repeat ($urandom_range(0, active_cols() - 1))
                    send_sample(random_sample());
                drain_stream();
                // columns only shrink here so no unwritten line entry is read
                write_reg(CFG_NUM_COLS, CFG_DATA_W'($urandom_range(0, active_cols())));
                write_reg(CFG_NUM_ROWS, CFG_DATA_W'($urandom_range(0, 10)));
                if ($urandom_range(0, 1) != 0)
                    write_reg(CFG_COEF_CENTER, random_coef());
            end
            finish_frame();
            drain_stream();
        end
    endtask

    // tallest row count at full rate: many rows go by without a frame wrap
    task automatic test_tall_frame();
        idle_on = 1'b0;
        write_reg(CFG_NUM_COLS, CFG_DATA_W'(3));
        write_reg(CFG_NUM_ROWS, 16'hFFFF);
        write_weights(random_coef(), random_coef(), random_coef(),
                      random_coef(), random_coef());
        repeat (90) send_sample(random_sample());
        drain_stream();
    endtask

    // ------------------------------------------------------------------
    // receiver: random ready gaps, plus the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap = $urandom_range(0, 5);
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: each master transfer against the oldest predicted point
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_result
        grid_point_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result transfer: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else begin
                want = pending_points.pop_front();
                if (m_axis_tdata[SAMPLE_W-1:0] !== want.value) begin
                    $error("out_value mismatch: expected %0d, actual %0d",
                           want.value, $signed(m_axis_tdata[SAMPLE_W-1:0]));
                    error_count++;
                end
                if (m_axis_tdata[SAMPLE_W +: ROW_W] !== want.row) begin
                    $error("out_row mismatch: expected %0d, actual %0d",
                           want.row, m_axis_tdata[SAMPLE_W +: ROW_W]);
                    error_count++;
                end
                if (m_axis_tdata[SAMPLE_W + ROW_W +: COL_W] !== want.col) begin
                    $error("out_col mismatch: expected %0d, actual %0d",
                           want.col, m_axis_tdata[SAMPLE_W + ROW_W +: COL_W]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_frame mismatch: expected %0d, actual %0d",
                           want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer or register write
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // predictor reset: line stores are never read before being written
        for (int i = 0; i < MAX_COLS; i++) begin
            upper_row_mem[i]  = '0;
            middle_row_mem[i] = '0;
        end
        grid_row    = 0;
        grid_col    = 0;
        left_sample = '0;
        cols_reg    = NUM_COLS_RST;
        rows_reg    = NUM_ROWS_RST;
        for (int t = 0; t < NUM_TAPS; t++)
            weight[t] = COEF_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_saturation();
        test_rounding();
        test_backpressure();
        test_large_width();
        test_random_frames();
        test_tall_frame();

        drain_stream();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
